// ===== rtl/cubemap_face_uv_select_defines.svh =====
// Assertion macros shared by the cube-map face selector RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef CUBEMAP_FACE_UV_SELECT_DEFINES_SVH
`define CUBEMAP_FACE_UV_SELECT_DEFINES_SVH

// same-cycle implication
`define CFUS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CFUS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cfus_pkg.sv =====
// Types and constants for the cube-map face selector.
// No dependencies; used by cfus_div_pipe and cubemap_face_uv_select.
package cfus_pkg;

  localparam int COMP_BITS_DEF = 16;
  localparam int FS_W          = 16;
  localparam logic [FS_W-1:0] FS_RESET = 16'd512;
  localparam logic [FS_W-1:0] FS_MIN   = 16'd2;

  // quotient bits per division and pipeline split
  localparam int QBITS         = 16;
  localparam int STEPS_PER_STG = 2;
  localparam int NSTG          = QBITS / STEPS_PER_STG;

  // divider lanes
  localparam int NLANES = 3;
  localparam int LANE_U = 0;
  localparam int LANE_V = 1;
  localparam int LANE_E = 2;

  localparam int FACE_W      = 3;
  localparam int OUT_TDATA_W = ((FACE_W + 2 * QBITS + 7) / 8) * 8;

  typedef enum logic [FACE_W-1:0] {
    FACE_PX = 3'd0,
    FACE_NX = 3'd1,
    FACE_PY = 3'd2,
    FACE_NY = 3'd3,
    FACE_PZ = 3'd4,
    FACE_NZ = 3'd5
  } cfus_face_e;

  typedef struct packed {
    cfus_face_e face;
    logic       neg_u;
    logic       neg_v;
    logic       degen;
  } cfus_side_t;

endpackage

// ===== rtl/cfus_div_pipe.sv =====
// Pipelined restoring divider, three lanes, two quotient bits per stage.
// Depends on cfus_pkg.
module cfus_div_pipe import cfus_pkg::*; #(
  parameter int COMP_BITS = COMP_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [((COMP_BITS > FS_W) ? COMP_BITS : FS_W):0]   rem_i [NLANES],
  input  logic [((COMP_BITS > FS_W) ? COMP_BITS : FS_W)-1:0] den_i [NLANES],
  input  cfus_side_t             side_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [QBITS-1:0]       quo_o [NLANES],
  output cfus_side_t             side_o
);

  localparam int DW = (COMP_BITS > FS_W) ? COMP_BITS : FS_W;
  localparam int RW = DW + 1;

  logic [RW-1:0]    rem_q [NSTG][NLANES];
  logic [DW-1:0]    den_q [NSTG][NLANES];
  logic [QBITS-1:0] quo_q [NSTG][NLANES];
  cfus_side_t       side_q [NSTG];
  logic [NSTG-1:0]  vld_q;
  logic [NSTG:0]    rdy;

  assign rdy[NSTG] = ready_i;
  assign ready_o   = rdy[0];

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    logic [RW-1:0]    prv_rem [NLANES];
    logic [DW-1:0]    prv_den [NLANES];
    logic [QBITS-1:0] prv_quo [NLANES];
    cfus_side_t       prv_side;
    logic             prv_vld;
    logic [RW-1:0]    nxt_rem [NLANES];
    logic [QBITS-1:0] nxt_quo [NLANES];

    if (k == 0) begin : g_src_in
      assign prv_rem  = rem_i;
      assign prv_den  = den_i;
      assign prv_quo  = '{default: '0};
      assign prv_side = side_i;
      assign prv_vld  = valid_i;
    end else begin : g_src_stg
      assign prv_rem  = rem_q[k-1];
      assign prv_den  = den_q[k-1];
      assign prv_quo  = quo_q[k-1];
      assign prv_side = side_q[k-1];
      assign prv_vld  = vld_q[k-1];
    end

    // remainder stays below twice the divisor between steps
    always_comb begin
      logic [RW-1:0]    r;
      logic [QBITS-1:0] qt;
      logic             b;
      for (int l = 0; l < NLANES; l++) begin
        r  = prv_rem[l];
        qt = prv_quo[l];
        for (int s = 0; s < STEPS_PER_STG; s++) begin
          b = (r >= {1'b0, prv_den[l]});
          if (b) begin
            r = r - {1'b0, prv_den[l]};
          end
          r  = {r[RW-2:0], 1'b0};
          qt = {qt[QBITS-2:0], b};
        end
        nxt_rem[l] = r;
        nxt_quo[l] = qt;
      end
    end

    assign rdy[k] = !vld_q[k] || rdy[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= prv_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && prv_vld) begin
        rem_q[k]  <= nxt_rem;
        den_q[k]  <= prv_den;
        quo_q[k]  <= nxt_quo;
        side_q[k] <= prv_side;
      end
    end
  end

  assign valid_o = vld_q[NSTG-1];
  assign quo_o   = quo_q[NSTG-1];
  assign side_o  = side_q[NSTG-1];

endmodule

// ===== rtl/cubemap_face_uv_select.sv =====
// Cube-map face selection with clamped Q0.16 face coordinates.
// Depends on cfus_pkg, cfus_div_pipe and cubemap_face_uv_select_defines.svh.
//
//   channel  dir   handshake                 payload
//   s_*      in    s_tvalid_i / s_tready_o   s_tdata_i: dir_x, dir_y, dir_z
//   m_*      out   m_tvalid_o / m_tready_i   m_tdata_o: face, coord_u, coord_v
//                                            m_tuser_o: degenerate
//   cfg_*    in    cfg_we_i                  cfg_wdata_i: face_size
//
// One transfer per cycle in and out while m_tready_i stays high, through
// one select stage, the divider pipe (16-bit restoring division, two
// quotient bits per stage) and one clamp/output stage.
// Reset clears all valid bits and sets face_size to 512.
// A stalled output holds; earlier stages keep filling until each is full.
`include "cubemap_face_uv_select_defines.svh"

module cubemap_face_uv_select import cfus_pkg::*; #(
  parameter int COMP_BITS = COMP_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_tvalid_i,
  output logic                                   s_tready_o,
  // dir_x, dir_y, dir_z
  input  logic [((3 * COMP_BITS + 7) / 8) * 8 - 1:0] s_tdata_i,
  output logic                                   m_tvalid_o,
  input  logic                                   m_tready_i,
  // face, coord_u, coord_v, zero pad
  output logic [OUT_TDATA_W-1:0]                 m_tdata_o,
  // degenerate
  output logic                                   m_tuser_o,
  input  logic                                   cfg_we_i,
  input  logic [FS_W-1:0]                        cfg_wdata_i
);

  localparam int DW = (COMP_BITS > FS_W) ? COMP_BITS : FS_W;
  localparam int RW = DW + 1;
  localparam int CB = COMP_BITS;
  localparam int PAD_W = OUT_TDATA_W - FACE_W - 2 * QBITS;
  localparam logic [QBITS:0] UNIT_C   = {1'b1, {QBITS{1'b0}}};
  localparam logic [QBITS:0] CENTRE_C = {2'b01, {(QBITS-1){1'b0}}};

  // config register
  logic [FS_W-1:0] fs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q <= FS_RESET;
    end else if (cfg_we_i) begin
      fs_q <= cfg_wdata_i;
    end
  end

  // select stage
  logic [CB-1:0]  dx, dy, dz, ax, ay, az;
  logic [CB-1:0]  mag_m, mag_s, mag_t;
  logic [FS_W-1:0] fs_sat;
  cfus_side_t     side_d;
  logic [RW-1:0]  rem_d [NLANES];
  logic [DW-1:0]  den_d [NLANES];

  logic           f_vld_q;
  logic [RW-1:0]  f_rem_q [NLANES];
  logic [DW-1:0]  f_den_q [NLANES];
  cfus_side_t     f_side_q;
  logic           f_rdy;

  logic             div_rdy, div_vld;
  logic [QBITS-1:0] div_quo [NLANES];
  cfus_side_t       div_side;

  logic             out_rdy;

  assign dx = s_tdata_i[CB-1:0];
  assign dy = s_tdata_i[2*CB-1:CB];
  assign dz = s_tdata_i[3*CB-1:2*CB];

  always_comb begin
    logic xn, yn, zn, xp, yp, zp;
    xn = dx[CB-1];
    yn = dy[CB-1];
    zn = dz[CB-1];
    xp = !xn && (|dx);
    yp = !yn && (|dy);
    zp = !zn && (|dz);
    ax = xn ? (~dx + 1'b1) : dx;
    ay = yn ? (~dy + 1'b1) : dy;
    az = zn ? (~dz + 1'b1) : dz;
    side_d = '0;
    if (ax >= ay && ax >= az) begin
      mag_m = ax;
      mag_s = az;
      mag_t = ay;
      side_d.neg_v = yp;
      if (!xn) begin
        side_d.face  = FACE_PX;
        side_d.neg_u = zp;
      end else begin
        side_d.face  = FACE_NX;
        side_d.neg_u = zn;
      end
    end else if (ay >= az) begin
      mag_m = ay;
      mag_s = ax;
      mag_t = az;
      side_d.neg_u = xn;
      if (!yn) begin
        side_d.face  = FACE_PY;
        side_d.neg_v = zn;
      end else begin
        side_d.face  = FACE_NY;
        side_d.neg_v = zp;
      end
    end else begin
      mag_m = az;
      mag_s = ax;
      mag_t = ay;
      side_d.neg_v = yp;
      if (!zn) begin
        side_d.face  = FACE_PZ;
        side_d.neg_u = xn;
      end else begin
        side_d.face  = FACE_NZ;
        side_d.neg_u = xp;
      end
    end
    side_d.degen = !(|{dx, dy, dz});
    if (side_d.degen) begin
      side_d.face = FACE_PX;
    end
  end

  assign fs_sat = (fs_q < FS_MIN) ? FS_MIN : fs_q;

  // eps lane: 2 * 2^15 / fs = 65536 / fs
  always_comb begin
    rem_d[LANE_U] = RW'(mag_s);
    rem_d[LANE_V] = RW'(mag_t);
    rem_d[LANE_E] = RW'(FS_MIN);
    den_d[LANE_U] = DW'(mag_m);
    den_d[LANE_V] = DW'(mag_m);
    den_d[LANE_E] = DW'(fs_sat);
  end

  assign f_rdy      = !f_vld_q || div_rdy;
  assign s_tready_o = f_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (f_rdy) begin
      f_vld_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_rdy && s_tvalid_i) begin
      f_rem_q  <= rem_d;
      f_den_q  <= den_d;
      f_side_q <= side_d;
    end
  end

  cfus_div_pipe #(
    .COMP_BITS(COMP_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_vld_q),
    .ready_o (div_rdy),
    .rem_i   (f_rem_q),
    .den_i   (f_den_q),
    .side_i  (f_side_q),
    .valid_o (div_vld),
    .ready_i (out_rdy),
    .quo_o   (div_quo),
    .side_o  (div_side)
  );

  // clamp / output stage
  function automatic logic [QBITS-1:0] clamp_coord(input logic neg,
                                                   input logic [QBITS-1:0] q,
                                                   input logic [QBITS-1:0] eps);
    logic [QBITS:0] c, lo, hi;
    c  = neg ? (CENTRE_C - {1'b0, q}) : (CENTRE_C + {1'b0, q});
    lo = {1'b0, eps};
    hi = UNIT_C - lo;
    if (c < lo) begin
      c = lo;
    end
    if (c > hi) begin
      c = hi;
    end
    return c[QBITS-1:0];
  endfunction

  logic             o_vld_q;
  cfus_face_e       o_face_q;
  logic [QBITS-1:0] o_u_q, o_v_q, u_d, v_d;
  logic             o_degen_q;

  always_comb begin
    if (div_side.degen) begin
      u_d = CENTRE_C[QBITS-1:0];
      v_d = CENTRE_C[QBITS-1:0];
    end else begin
      u_d = clamp_coord(div_side.neg_u, div_quo[LANE_U], div_quo[LANE_E]);
      v_d = clamp_coord(div_side.neg_v, div_quo[LANE_V], div_quo[LANE_E]);
    end
  end

  assign out_rdy = !o_vld_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (out_rdy) begin
      o_vld_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && div_vld) begin
      o_face_q  <= div_side.face;
      o_u_q     <= u_d;
      o_v_q     <= v_d;
      o_degen_q <= div_side.degen;
    end
  end

  assign m_tvalid_o = o_vld_q;
  assign m_tdata_o  = {{PAD_W{1'b0}}, o_v_q, o_u_q, o_face_q};
  assign m_tuser_o  = o_degen_q;

  localparam logic [QBITS-1:0] HALF_C = CENTRE_C[QBITS-1:0];

  logic o_at_centre, o_in_margin, quo_ok;

  assign o_at_centre = (o_face_q == FACE_PX) && (o_u_q == HALF_C) && (o_v_q == HALF_C);
  assign o_in_margin = (o_u_q != '0) && (o_v_q != '0);
  assign quo_ok      = (div_quo[LANE_U] <= HALF_C) && (div_quo[LANE_V] <= HALF_C)
                       && (div_quo[LANE_E] != '0);

  `CFUS_ASSERT_NOW(a_degen_centre, o_vld_q && o_degen_q, o_at_centre, "degenerate not centred")
  `CFUS_ASSERT_NOW(a_margin, o_vld_q && !o_degen_q, o_in_margin, "coordinate on the edge")
  `CFUS_ASSERT_NOW(a_quo_range, div_vld && !div_side.degen, quo_ok, "quotient out of range")
  `CFUS_ASSERT_NXT(a_out_load, div_vld && out_rdy, o_vld_q, "output not loaded")

endmodule
